// ----- rtl/blsi_pkg.sv -----
// shared types, constants and the per-axis slab update for the box/line slab test
// no dependencies
package blsi_pkg;

    localparam int T_W     = 48;   // parameter (t) width, signed
    localparam int COORD_W = 32;   // coordinate width, signed
    localparam int MAG_W   = 32;   // magnitude width of numerators and directions
    localparam int TOL_W   = 31;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] KIND_RAY  = 2'd0;
    localparam logic [1:0] KIND_LINE = 2'd1;
    localparam logic [1:0] KIND_SEG  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL   = 3'd4;

    // per-axis control that travels beside the dividers
    typedef struct packed {
        logic par;     // direction within tolerance
        logic dneg;    // direction negative
        logic pin;     // start inside slab (used when parallel)
        logic sgn_lo;  // quotient for lower corner is negative
        logic sgn_hi;  // quotient for upper corner is negative
    } t_slab;

    typedef struct packed {
        logic [1:0] kind;
        t_slab      x;
        t_slab      y;
    } t_side;

    typedef struct packed {
        logic                  ok;
        logic signed [T_W-1:0] tn;
        logic signed [T_W-1:0] tf;
    } t_span;

    function automatic t_span slab_step(
        input t_slab                 s,
        input logic signed [T_W-1:0] t_lo,
        input logic signed [T_W-1:0] t_hi,
        input logic signed [T_W-1:0] tn,
        input logic signed [T_W-1:0] tf
    );
        t_span                 o;
        logic signed [T_W-1:0] t1;
        logic signed [T_W-1:0] t2;
        o.ok = 1'b1;
        o.tn = tn;
        o.tf = tf;
        t1   = s.dneg ? t_lo : t_hi;
        t2   = s.dneg ? t_hi : t_lo;
        if (s.par) begin
            o.ok = s.pin;
        end else if (t1 < tn) begin
            o.ok = 1'b0;
        end else begin
            if (t1 <= tf) begin
                o.tf = t1;
            end
            if (t2 >= tn) begin
                if (t2 > o.tf) begin
                    o.ok = 1'b0;
                end else begin
                    o.tn = t2;
                end
            end
        end
        return o;
    endfunction

endpackage

// ----- rtl/blsi_div.sv -----
// pipelined unsigned restoring divider, one quotient bit per stage
// computes (num * 2^FRAC) / den; depends on blsi_pkg
module blsi_div
    import blsi_pkg::*;
#(
    parameter int FRAC = 24
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [MAG_W-1:0]      i_num,
    input  logic [MAG_W-1:0]      i_den,
    output logic [MAG_W+FRAC-1:0] o_quo
);

    localparam int QW = MAG_W + FRAC;

    logic [MAG_W-1:0] s_rem [QW];
    logic [QW-1:0]    s_nq  [QW];
    logic [MAG_W-1:0] s_den [QW];

    logic [MAG_W-1:0] r_rem [QW-1];
    logic [QW-1:0]    r_nq  [QW];
    logic [MAG_W-1:0] r_den [QW-1];

    assign s_rem[0] = '0;
    assign s_nq[0]  = {i_num, {FRAC{1'b0}}};
    assign s_den[0] = i_den;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [MAG_W:0] rs;
        logic [MAG_W:0] diff;
        logic           ge;

        assign rs   = {s_rem[k], s_nq[k][QW-1]};
        assign diff = rs - {1'b0, s_den[k]};
        assign ge   = rs >= {1'b0, s_den[k]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nq[k] <= {s_nq[k][QW-2:0], ge};
            end
        end

        if (k < QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? diff[MAG_W-1:0] : rs[MAG_W-1:0];
                    r_den[k] <= s_den[k];
                end
            end
            assign s_rem[k+1] = r_rem[k];
            assign s_nq[k+1]  = r_nq[k];
            assign s_den[k+1] = r_den[k];
        end
    end

    assign o_quo = r_nq[QW-1];

endmodule

// ----- rtl/box_line_slab_intersect_core.sv -----
// top level of the 2d box slab test: config registers, pipeline control, axis merge
// depends on blsi_pkg and blsi_div
// Streams rays, lines and segments against an axis-aligned box held in configuration
// registers and returns one result transaction per input transaction. One transaction
// is accepted every cycle while the output is not stalled; the pipeline is the four
// one-bit-per-stage dividers (32 + PARAM_FRAC_BITS stages) plus five stages of setup,
// saturation and slab merging and the output register. The whole pipeline advances
// together and holds only while the output register is full and stalled, so o_stall
// follows i_stall in that case. The box, the parallel tolerance and every slab
// parameter are exact two's complement fixed point: coordinates and the box in
// Q16.16, t_near and t_far in 48-bit signed with PARAM_FRAC_BITS fraction bits,
// saturated to the 48-bit range and reported as zero on a miss. Segments are
// clamped to [0, 1]. Config writes are always ready and must only happen while idle.
module box_line_slab_intersect_core
    import blsi_pkg::*;
#(
    parameter int PARAM_FRAC_BITS = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_kind,
    input  logic signed [COORD_W-1:0]   i_start_x,
    input  logic signed [COORD_W-1:0]   i_start_y,
    input  logic signed [COORD_W-1:0]   i_second_x,
    input  logic signed [COORD_W-1:0]   i_second_y,
    // output channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_hit,
    output logic signed [T_W-1:0]       o_t_near,
    output logic signed [T_W-1:0]       o_t_far,
    // config write channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [COORD_W-1:0]          i_cfg_data
);

    localparam int QW = MAG_W + PARAM_FRAC_BITS;
    localparam int CW = (QW > T_W) ? QW : T_W;

    // config registers
    logic signed [COORD_W-1:0] r_box_min_x, r_box_min_y, r_box_max_x, r_box_max_y;
    logic [TOL_W-1:0]          r_tol;

    // pipeline enable: everything moves unless the output is full and stalled
    logic en;
    assign en          = !(o_valid && i_stall);
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_min_x <= '0;
            r_box_min_y <= '0;
            r_box_max_x <= 32'sd65536;
            r_box_max_y <= 32'sd65536;
            r_tol       <= 31'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MIN_X: r_box_min_x <= i_cfg_data;
                CFG_MIN_Y: r_box_min_y <= i_cfg_data;
                CFG_MAX_X: r_box_max_x <= i_cfg_data;
                CFG_MAX_Y: r_box_max_y <= i_cfg_data;
                CFG_TOL:   r_tol       <= i_cfg_data[TOL_W-1:0];
                default:   ;
            endcase
        end
    end

    // ---------------- stage 1: capture, direction ----------------
    logic                      r_s1_valid;
    logic [1:0]                r_s1_kind;
    logic signed [COORD_W-1:0] r_s1_px, r_s1_py;
    logic signed [COORD_W:0]   r_s1_dx, r_s1_dy;
    logic signed [COORD_W:0]   n_dx, n_dy;

    always_comb begin
        if (i_kind != KIND_RAY) begin
            n_dx = {i_second_x[COORD_W-1], i_second_x} - {i_start_x[COORD_W-1], i_start_x};
            n_dy = {i_second_y[COORD_W-1], i_second_y} - {i_start_y[COORD_W-1], i_start_y};
        end else begin
            n_dx = {i_second_x[COORD_W-1], i_second_x};
            n_dy = {i_second_y[COORD_W-1], i_second_y};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_kind <= i_kind;
            r_s1_px   <= i_start_x;
            r_s1_py   <= i_start_y;
            r_s1_dx   <= n_dx;
            r_s1_dy   <= n_dy;
        end
    end

    // ---------------- stage 2: classify axes, form magnitudes ----------------
    logic             r_s2_valid;
    t_side            r_s2_side;
    logic [MAG_W-1:0] r_s2_num [4];   // x lo, x hi, y lo, y hi
    logic [MAG_W-1:0] r_s2_den [2];   // x, y
    t_side            n_side;
    logic [MAG_W-1:0] n_num [4];
    logic [MAG_W-1:0] n_den [2];

    always_comb begin
        logic signed [COORD_W:0] p  [2];
        logic signed [COORD_W:0] d  [2];
        logic signed [COORD_W:0] lo [2];
        logic signed [COORD_W:0] hi [2];
        logic signed [COORD_W:0] tol;
        logic signed [COORD_W:0] nlo, nhi;
        t_slab                   s [2];
        p[0]  = {r_s1_px[COORD_W-1], r_s1_px};
        p[1]  = {r_s1_py[COORD_W-1], r_s1_py};
        d[0]  = r_s1_dx;
        d[1]  = r_s1_dy;
        lo[0] = {r_box_min_x[COORD_W-1], r_box_min_x};
        lo[1] = {r_box_min_y[COORD_W-1], r_box_min_y};
        hi[0] = {r_box_max_x[COORD_W-1], r_box_max_x};
        hi[1] = {r_box_max_y[COORD_W-1], r_box_max_y};
        tol   = {2'b00, r_tol};
        for (int a = 0; a < 2; a++) begin
            nlo          = lo[a] - p[a];
            nhi          = hi[a] - p[a];
            s[a].dneg    = d[a] < -tol;
            s[a].par     = !(d[a] < -tol) && !(d[a] > tol);
            s[a].pin     = !(p[a] < lo[a] || p[a] > hi[a]);
            s[a].sgn_lo  = nlo[COORD_W] != d[a][COORD_W];
            s[a].sgn_hi  = nhi[COORD_W] != d[a][COORD_W];
            n_num[2*a]   = nlo[COORD_W] ? MAG_W'(-nlo) : nlo[MAG_W-1:0];
            n_num[2*a+1] = nhi[COORD_W] ? MAG_W'(-nhi) : nhi[MAG_W-1:0];
            n_den[a]     = d[a][COORD_W] ? MAG_W'(-d[a]) : d[a][MAG_W-1:0];
        end
        n_side.kind = r_s1_kind;
        n_side.x    = s[0];
        n_side.y    = s[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_side <= n_side;
            r_s2_num  <= n_num;
            r_s2_den  <= n_den;
        end
    end

    // ---------------- divider stages ----------------
    logic [QW-1:0] quo [4];

    for (genvar g = 0; g < 4; g++) begin : g_div
        blsi_div #(
            .FRAC (PARAM_FRAC_BITS)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_s2_num[g]),
            .i_den (r_s2_den[g / 2]),
            .o_quo (quo[g])
        );
    end

    // side information delayed alongside the dividers
    logic  r_dv_valid [QW];
    t_side r_dv_side  [QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QW; k++) begin
                r_dv_valid[k] <= 1'b0;
            end
        end else if (en) begin
            r_dv_valid[0] <= r_s2_valid;
            for (int k = 1; k < QW; k++) begin
                r_dv_valid[k] <= r_dv_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_side[0] <= r_s2_side;
            for (int k = 1; k < QW; k++) begin
                r_dv_side[k] <= r_dv_side[k-1];
            end
        end
    end

    // ---------------- stage 3: saturate and sign ----------------
    logic                  r_s3_valid;
    t_side                 r_s3_side;
    logic signed [T_W-1:0] r_s3_t [4];
    logic signed [T_W-1:0] n_t [4];
    logic                  q_neg [4];

    assign q_neg[0] = r_dv_side[QW-1].x.sgn_lo;
    assign q_neg[1] = r_dv_side[QW-1].x.sgn_hi;
    assign q_neg[2] = r_dv_side[QW-1].y.sgn_lo;
    assign q_neg[3] = r_dv_side[QW-1].y.sgn_hi;

    always_comb begin
        logic [CW-1:0]  qe;
        logic [CW-1:0]  lim;
        logic [T_W-1:0] qs;
        for (int g = 0; g < 4; g++) begin
            qe  = CW'(quo[g]);
            // 2^47 for negative results, 2^47 - 1 otherwise
            lim = (CW'(1) << (T_W - 1)) - CW'(!q_neg[g]);
            qs  = (qe > lim) ? lim[T_W-1:0] : qe[T_W-1:0];
            n_t[g] = q_neg[g] ? -qs : qs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (en) begin
            r_s3_valid <= r_dv_valid[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_side <= r_dv_side[QW-1];
            r_s3_t    <= n_t;
        end
    end

    // ---------------- stage 4: x slab ----------------
    localparam logic signed [T_W-1:0] T_MAX = {1'b0, {(T_W-1){1'b1}}};
    localparam logic signed [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};

    logic                  r_s4_valid;
    t_side                 r_s4_side;
    t_span                 r_s4_span;
    logic signed [T_W-1:0] r_s4_tylo, r_s4_tyhi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (en) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_side <= r_s3_side;
            r_s4_span <= slab_step(r_s3_side.x, r_s3_t[0], r_s3_t[1], T_MIN, T_MAX);
            r_s4_tylo <= r_s3_t[2];
            r_s4_tyhi <= r_s3_t[3];
        end
    end

    // ---------------- stage 5: y slab ----------------
    logic       r_s5_valid;
    logic [1:0] r_s5_kind;
    t_span      r_s5_span;
    t_span      n_yspan;

    always_comb begin
        n_yspan    = slab_step(r_s4_side.y, r_s4_tylo, r_s4_tyhi, r_s4_span.tn,
                               r_s4_span.tf);
        n_yspan.ok = n_yspan.ok && r_s4_span.ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else if (en) begin
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s5_kind <= r_s4_side.kind;
            r_s5_span <= n_yspan;
        end
    end

    // ---------------- output register: segment clamp, zero on miss ----------------
    localparam logic signed [T_W-1:0] T_ONE = T_W'(1) << PARAM_FRAC_BITS;

    logic                  r_out_valid;
    logic                  r_out_hit;
    logic signed [T_W-1:0] r_out_tn, r_out_tf;
    logic                  n_hit;
    logic signed [T_W-1:0] n_tn, n_tf;

    always_comb begin
        n_hit = r_s5_span.ok;
        n_tn  = r_s5_span.tn;
        n_tf  = r_s5_span.tf;
        if (n_hit && r_s5_kind == KIND_SEG) begin
            if (n_tn < 0) begin
                n_tn = '0;
            end
            if (n_tf > T_ONE) begin
                n_tf = T_ONE;
            end
            n_hit = n_tn < n_tf;
        end
        if (!n_hit) begin
            n_tn = '0;
            n_tf = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_s5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_hit <= n_hit;
            r_out_tn  <= n_tn;
            r_out_tf  <= n_tf;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_hit    = r_out_hit;
    assign o_t_near = r_out_tn;
    assign o_t_far  = r_out_tf;

    // ---------------- assertions ----------------
    a_miss_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_t_near == '0 && o_t_far == '0)
        else $error("miss with nonzero parameters");

    a_hit_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> o_t_near <= o_t_far)
        else $error("entry parameter beyond exit parameter");

    a_stall_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled while output register empty");

    a_tol_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && i_cfg_index == CFG_TOL |=> r_tol == $past(i_cfg_data[TOL_W-1:0]))
        else $error("tolerance write lost");

endmodule

// ----- bench/testbench.sv -----
// self-checking bench for the 2d box slab intersection core
// depends on blsi_pkg and box_line_slab_intersect_core
`timescale 1ns / 100ps

// scoreboard: keeps the configured box, predicts each slab result and checks outputs
class slab_scoreboard;
    localparam int PFB = 24;

    logic signed [63:0] box_lo_x, box_lo_y, box_hi_x, box_hi_y;
    logic signed [63:0] tol;

    // expected hit and parameters, oldest first
    logic [96:0] pending_hits[$];
    int mismatches;
    int checked;

    function void reset_regs();
        box_lo_x = 0;
        box_lo_y = 0;
        box_hi_x = 65536;
        box_hi_y = 65536;
        tol      = 1;
        pending_hits.delete();
        mismatches = 0;
        checked    = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
        case (idx)
            blsi_pkg::CFG_MIN_X: box_lo_x = 64'(signed'(data));
            blsi_pkg::CFG_MIN_Y: box_lo_y = 64'(signed'(data));
            blsi_pkg::CFG_MAX_X: box_hi_x = 64'(signed'(data));
            blsi_pkg::CFG_MAX_Y: box_hi_y = 64'(signed'(data));
            blsi_pkg::CFG_TOL:   tol = {33'd0, data[30:0]};
            default: ;
        endcase
    endfunction

    // num * 2^PFB / den, truncated toward zero, saturated to 48 bits
    function logic signed [63:0] scaled_quotient(logic signed [63:0] num,
                                                 logic signed [63:0] den);
        logic       neg;
        logic [63:0] n, d, q, r, lim;
        logic       sat;
        neg = (num < 0) != (den < 0);
        n   = num < 0 ? -num : num;
        d   = den < 0 ? -den : den;
        lim = neg ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
        q   = n / d;
        r   = n % d;
        sat = q > lim;
        for (int i = 0; i < PFB && !sat; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q[0] = 1'b1;
            end
            if (q > lim) sat = 1'b1;
        end
        if (sat) q = lim;
        return neg ? -$signed(q) : $signed(q);
    endfunction

    // clip one axis into [tn, tf]; returns 0 on a miss
    function bit clip_axis(logic signed [63:0] p, logic signed [63:0] d,
                           logic signed [63:0] lo, logic signed [63:0] hi,
                           inout logic signed [63:0] tn, inout logic signed [63:0] tf);
        logic signed [63:0] entry_c, exit_c, t;
        if (d < -tol) begin
            entry_c = lo;
            exit_c  = hi;
        end else if (d > tol) begin
            entry_c = hi;
            exit_c  = lo;
        end else begin
            return !(p < lo || p > hi);
        end
        t = scaled_quotient(entry_c - p, d);
        if (t < tn) return 0;
        if (t <= tf) tf = t;
        t = scaled_quotient(exit_c - p, d);
        if (t >= tn) begin
            if (t > tf) return 0;
            tn = t;
        end
        return 1;
    endfunction

    function void note_input(logic [1:0] kind, logic signed [31:0] sx, logic signed [31:0] sy,
                             logic signed [31:0] qx, logic signed [31:0] qy);
        logic signed [63:0] px, py, dx, dy, tn, tf;
        bit hit;
        px = sx;
        py = sy;
        dx = qx;
        dy = qy;
        tn = -(64'sd1 <<< 47);
        tf = (64'sd1 <<< 47) - 1;
        if (kind != blsi_pkg::KIND_RAY) begin
            dx = dx - px;
            dy = dy - py;
        end
        hit = clip_axis(px, dx, box_lo_x, box_hi_x, tn, tf);
        if (hit) hit = clip_axis(py, dy, box_lo_y, box_hi_y, tn, tf);
        if (hit && kind == blsi_pkg::KIND_SEG) begin
            if (tn < 0) tn = 0;
            if (tf > (64'sd1 <<< PFB)) tf = 64'sd1 <<< PFB;
            hit = tn < tf;
        end
        if (!hit) begin
            tn = 0;
            tf = 0;
        end
        pending_hits.push_back({hit, tn[47:0], tf[47:0]});
    endfunction

    function void check_result(logic hit, logic [47:0] tn, logic [47:0] tf);
        logic [96:0] want;
        checked++;
        if (pending_hits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transaction hit=%0b", hit);
            return;
        end
        want = pending_hits.pop_front();
        if (want[96] !== hit || want[95:48] !== tn || want[47:0] !== tf) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected hit=%0b tn=%h tf=%h, got hit=%0b tn=%h tf=%h",
                         want[96], want[95:48], want[47:0], hit, tn, tf);
        end
    endfunction
endclass

module testbench;
    import blsi_pkg::*;

    localparam int LATENCY   = 24 + 38;
    localparam int WATCHDOG  = 5000;
    localparam int RAND_ITEMS = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic i_valid = 1'b0;
    logic o_stall;
    logic [1:0] i_kind = '0;
    logic signed [31:0] i_start_x = '0, i_start_y = '0, i_second_x = '0, i_second_y = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic o_hit;
    logic signed [47:0] o_t_near, o_t_far;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    slab_scoreboard sb = new();

    // receiver control: random stall pattern, or a long forced hold-off
    int  stall_pct = 30;
    bit  hold_off  = 1'b0;
    int  idle_cycles = 0;
    bit  timed_out = 1'b0;
    int  sent = 0;

    always #10 i_clk = ~i_clk;

    box_line_slab_intersect_core uut (.*);

    // check every accepted result; both sides sampled on the same edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_hit, o_t_near, o_t_far);
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (hold_off) i_stall <= 1'b1;
        else i_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog on cycles without any accepted transaction
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || sb.pending_hits.size() == 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog expired with %0d results outstanding", sb.pending_hits.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    // offer one transaction and hold it until accepted
    task automatic send_item(logic [1:0] kind, logic [31:0] sx, logic [31:0] sy,
                             logic [31:0] qx, logic [31:0] qy);
        i_valid    <= 1'b1;
        i_kind     <= kind;
        i_start_x  <= sx;
        i_start_y  <= sy;
        i_second_x <= qx;
        i_second_y <= qy;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(kind, sx, sy, qx, qy);
        sent++;
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending_hits.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // the caller drops i_cfg_valid after the last write of a sequence
    task automatic write_cfg(logic [2:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic set_box(logic [31:0] lx, logic [31:0] ly, logic [31:0] hx,
                           logic [31:0] hy, logic [31:0] t);
        write_cfg(CFG_MIN_X, lx);
        write_cfg(CFG_MIN_Y, ly);
        write_cfg(CFG_MAX_X, hx);
        write_cfg(CFG_MAX_Y, hy);
        write_cfg(CFG_TOL, t);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // coordinate mostly near the box, sometimes anywhere in range
    function automatic logic [31:0] near_coord();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(8 * 65536)) - 4 * 65536);
            2: return 32'($signed($urandom_range(400)) - 200);
            default: return 32'($signed($urandom_range(4 * 65536)) - 65536);
        endcase
    endfunction

    function automatic logic [1:0] rand_kind();
        return ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
    endfunction

    // random phase: bursts of back-to-back transactions with random gaps
    task automatic random_phase(int count);
        int n = 0;
        int burst;
        while (n < count) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < count; b++) begin
                send_item(rand_kind(), near_coord(), near_coord(), near_coord(), near_coord());
                n++;
            end
            if ($urandom_range(3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        sb.reset_regs();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset box, every kind, parallel axes, field extremes
        send_item(KIND_RAY,  32'hFFFF_8000, 32'h0000_8000, 32'h0001_0000, 32'h0);
        send_item(KIND_RAY,  32'h0002_0000, 32'h0000_8000, 32'hFFFF_0000, 32'h1);
        send_item(KIND_LINE, 32'hFFFF_0000, 32'hFFFF_0000, 32'h0002_0000, 32'h0002_0000);
        send_item(KIND_SEG,  32'h0000_4000, 32'h0000_4000, 32'h0000_C000, 32'h0000_C000);
        send_item(KIND_SEG,  32'h0003_0000, 32'h0003_0000, 32'h0004_0000, 32'h0004_0000);
        send_item(KIND_SEG,  32'hFFFF_0000, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
        send_item(2'd3,      32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(KIND_RAY,  32'h0, 32'h0, 32'h0, 32'h0);
        send_item(KIND_RAY,  32'h0000_8000, 32'h0000_8000, 32'hFFFF_FFFF, 32'h0000_0002);
        send_item(KIND_LINE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(KIND_RAY,  32'h0000_8000, 32'h0000_8000, 32'h0000_0002, 32'h8000_0000);
        send_item(KIND_SEG,  32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000);
        drain();

        // zero tolerance and an inverted box
        set_box(32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0001_0000, 32'h0);
        send_item(KIND_RAY,  32'h0000_8000, 32'h0, 32'h0, 32'h0001_0000);
        send_item(KIND_LINE, 32'hFFFE_0000, 32'h0, 32'h0002_0000, 32'h0);
        send_item(KIND_SEG,  32'h0000_8000, 32'hFFFE_0000, 32'h0000_8001, 32'h0002_0000);
        send_item(KIND_RAY,  32'h0, 32'h0, 32'h0000_0001, 32'hFFFF_FFFF);
        drain();

        // extreme box and largest tolerance
        set_box(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(KIND_RAY,  32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(KIND_LINE, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0);
        drain();
        set_box(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
        send_item(KIND_RAY,  32'h0, 32'h0, 32'h0000_0001, 32'h0000_0001);
        send_item(KIND_SEG,  32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        drain();

        // random phases over several box settings
        for (int ph = 0; ph < 5; ph++) begin
            if (ph == 0) set_box(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h1);
            else set_box(near_coord(), near_coord(), near_coord(), near_coord(),
                         (ph == 4) ? 32'h0 : 32'($urandom_range(0, 4096)));
            stall_pct = (ph == 2) ? 0 : 10 * ph;
            if (ph == 3) begin
                // long receiver hold-off while the sender keeps pushing
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (LATENCY * 3) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                    random_phase(RAND_ITEMS / 5);
                join
            end else begin
                random_phase(RAND_ITEMS / 5);
            end
            // sender pauses until every result has come back
            drain();
        end

        drain();
        $display("covered %0d transactions, %0d results checked, 9 box settings",
                 sent, sb.checked);
        $display("rays, lines, segments, unused kind, parallel and inverted-box cases");
        if (sb.mismatches == 0 && sb.pending_hits.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/blsi_pkg.sv
rtl/blsi_div.sv
rtl/box_line_slab_intersect_core.sv
bench/testbench.sv
